@@ design/rvm_pkg.sv @@
// ----------------------------------------------------------------------------
// rvm_pkg
// Shared types, command codes and helpers for the register VM execute unit.
// ----------------------------------------------------------------------------
package rvm_pkg;

  localparam int unsigned NumRegs  = 32;
  localparam int unsigned RegIdxW  = 5;
  localparam int unsigned XLEN     = 64;
  localparam int unsigned ShiftW   = 6;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [3:0] {
    CmdNop  = 4'd0,  CmdMov  = 4'd1,  CmdAdd  = 4'd2,  CmdSub  = 4'd3,
    CmdMuli = 4'd4,  CmdMulu = 4'd5,  CmdDivi = 4'd6,  CmdDivu = 4'd7,
    CmdRemi = 4'd8,  CmdRemu = 4'd9,  CmdShl  = 4'd10, CmdShr  = 4'd11,
    CmdSar  = 4'd12, CmdJnz  = 4'd13, CmdRsv0 = 4'd14, CmdRsv1 = 4'd15
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle, StRead, StExec, StMul, StDiv, StWrite, StOut
  } state_e;

  // Start request and status between sequencer and divider
  typedef struct packed {
    logic            start;
    logic            is_signed;
    logic [XLEN-1:0] dividend;
    logic [XLEN-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [XLEN-1:0] quot;
    logic [XLEN-1:0] rem;
  } div_rsp_t;

  function automatic logic [XLEN-1:0] size_mask(input logic [1:0] sz);
    logic [XLEN-1:0] m;
    case (sz)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

@@ design/register_vm_execute_unit_core.sv @@
// ----------------------------------------------------------------------------
// register_vm_execute_unit_core
// Execute stage of a register bytecode machine with a 32 x 64 register file.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata (low bit first)                        | tuser
// s_axis  | in  | command,dest_index,dest_size,src1_is_imm,    | -
//         |     | src1_index,src1_size,src2_is_imm,src2_index, |
//         |     | src2_size,immediate (91 bits, 5 zero pad)    |
// m_axis  | out | dest_value,branch_taken,divide_error (66+6)  | -
// Steps for simple commands: accept in idle, read, execute, write and
// deliver; multiplies add a multiply state on the shared 32 x 32 multiplier,
// divide and remainder add a wait on the radix-2 divider (none on a zero
// divisor). Register file reads three ports a cycle from flip-flops cleared
// at reset. s_axis_tready is high only in idle; the result register waits
// for m_axis_tready and no new request is taken until it is taken.
// ----------------------------------------------------------------------------
module register_vm_execute_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[3:0] dest_index[8:4] dest_size[10:9] src1_is_imm[11]
  // src1_index[16:12] src1_size[18:17] src2_is_imm[19] src2_index[24:20]
  // src2_size[26:25] immediate[90:27]
  input  logic [rvm_pkg::InDataW-1:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // dest_value[63:0] branch_taken[64] divide_error[65]
  output logic [rvm_pkg::OutDataW-1:0] m_axis_tdata
);
  localparam int unsigned W = rvm_pkg::XLEN;

  rvm_pkg::state_e st_q, st_d;
  logic [W-1:0] regs_q [rvm_pkg::NumRegs];
  logic [90:0]  ins_q;
  logic [W-1:0] s1_q, s2_q, res_q, res_d, out_q;
  logic         wr_q, wr_d, tk_q, tk_d, de_q, de_d, tko_q, deo_q;
  logic [1:0]   mcnt_q, mcnt_d;
  logic [31:0]  mop_a, mop_b;
  logic [W-1:0] mprod;
  rvm_pkg::div_req_t dreq;
  rvm_pkg::div_rsp_t drsp;

  rvm_pkg::cmd_e cmd;
  logic [rvm_pkg::RegIdxW-1:0] dix, s1ix, s2ix;
  logic [1:0] dsz, s1sz, s2sz;
  logic [W-1:0] imm, rd1, rd2, dold;
  logic [5:0] sh;

  assign cmd  = rvm_pkg::cmd_e'(ins_q[3:0]);
  assign dix  = ins_q[8:4];
  assign dsz  = ins_q[10:9];
  assign s1ix = ins_q[16:12];
  assign s1sz = ins_q[18:17];
  assign s2ix = ins_q[24:20];
  assign s2sz = ins_q[26:25];
  assign imm  = ins_q[90:27];
  assign rd1  = regs_q[s1ix] & rvm_pkg::size_mask(s1sz);
  assign rd2  = regs_q[s2ix] & rvm_pkg::size_mask(s2sz);
  assign dold = regs_q[dix];
  assign sh   = s2_q[rvm_pkg::ShiftW-1:0];

  rvm_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  logic is_div, is_mul;
  assign is_div = (cmd == rvm_pkg::CmdDivi) || (cmd == rvm_pkg::CmdDivu) ||
                  (cmd == rvm_pkg::CmdRemi) || (cmd == rvm_pkg::CmdRemu);
  assign is_mul = (cmd == rvm_pkg::CmdMuli) || (cmd == rvm_pkg::CmdMulu);

  // Shared 32 x 32 multiplier: low x low, then high x low, then low x high
  always_comb begin
    case (mcnt_q)
      2'd1: begin
        mop_a = s1_q[63:32];
        mop_b = s2_q[31:0];
      end
      2'd2: begin
        mop_a = s1_q[31:0];
        mop_b = s2_q[63:32];
      end
      default: begin
        mop_a = s1_q[31:0];
        mop_b = s2_q[31:0];
      end
    endcase
  end
  assign mprod = W'(mop_a) * W'(mop_b);

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      rvm_pkg::StIdle:  if (s_axis_tvalid) st_d = rvm_pkg::StRead;
      rvm_pkg::StRead:  st_d = rvm_pkg::StExec;
      rvm_pkg::StExec: begin
        if (is_div && s2_q != '0) st_d = rvm_pkg::StDiv;
        else if (is_mul)          st_d = rvm_pkg::StMul;
        else                      st_d = rvm_pkg::StWrite;
      end
      rvm_pkg::StMul:   if (mcnt_q == 2'd2) st_d = rvm_pkg::StWrite;
      rvm_pkg::StDiv:   if (drsp.done) st_d = rvm_pkg::StWrite;
      rvm_pkg::StWrite: st_d = rvm_pkg::StOut;
      rvm_pkg::StOut:   if (m_axis_tready) st_d = rvm_pkg::StIdle;
      default:          st_d = rvm_pkg::StIdle;
    endcase
  end

  // Outputs and execute datapath
  always_comb begin
    s_axis_tready  = (st_q == rvm_pkg::StIdle);
    m_axis_tvalid  = (st_q == rvm_pkg::StOut);
    dreq.start     = (st_q == rvm_pkg::StExec) && is_div && (s2_q != '0);
    dreq.is_signed = (cmd == rvm_pkg::CmdDivi) || (cmd == rvm_pkg::CmdRemi);
    dreq.dividend  = s1_q;
    dreq.divisor   = s2_q;
    res_d  = res_q;
    wr_d   = wr_q;
    tk_d   = tk_q;
    de_d   = de_q;
    mcnt_d = mcnt_q;
    if (st_q == rvm_pkg::StExec) begin
      wr_d = 1'b1;
      tk_d = 1'b0;
      de_d = 1'b0;
      res_d = '0;
      mcnt_d = 2'd0;
      case (cmd)
        rvm_pkg::CmdMov:  res_d = s1_q;
        rvm_pkg::CmdAdd:  res_d = s1_q + s2_q;
        rvm_pkg::CmdSub:  res_d = s1_q - s2_q;
        rvm_pkg::CmdMuli,
        rvm_pkg::CmdMulu: res_d = '0;
        rvm_pkg::CmdShl:  res_d = s1_q << sh;
        rvm_pkg::CmdShr:  res_d = s1_q >> sh;
        rvm_pkg::CmdSar:  res_d = W'($signed(s1_q) >>> sh);
        rvm_pkg::CmdDivi, rvm_pkg::CmdDivu, rvm_pkg::CmdRemi, rvm_pkg::CmdRemu: begin
          if (s2_q == '0) begin
            de_d = 1'b1;
            wr_d = 1'b0;
          end
        end
        rvm_pkg::CmdJnz: begin
          wr_d = 1'b0;
          tk_d = (dold & rvm_pkg::size_mask(dsz)) != '0;
        end
        default: wr_d = 1'b0;
      endcase
    end else if (st_q == rvm_pkg::StMul) begin
      // Accumulate partial products; cross terms only reach the upper half
      res_d  = (mcnt_q == 2'd0) ? mprod : (res_q + {mprod[31:0], 32'd0});
      mcnt_d = mcnt_q + 2'd1;
    end else if (st_q == rvm_pkg::StDiv && drsp.done) begin
      res_d = (cmd == rvm_pkg::CmdDivi || cmd == rvm_pkg::CmdDivu) ? drsp.quot
                                                                   : drsp.rem;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= rvm_pkg::StIdle;
      wr_q   <= 1'b0;
      mcnt_q <= 2'd0;
    end else begin
      st_q   <= st_d;
      wr_q   <= wr_d;
      mcnt_q <= mcnt_d;
    end
  end

  // Register file, cleared at reset; sized write keeps upper bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rvm_pkg::NumRegs; i++) regs_q[i] <= '0;
    end else if (st_q == rvm_pkg::StWrite && wr_q) begin
      regs_q[dix] <= (dold & ~rvm_pkg::size_mask(dsz)) |
                     (res_q & rvm_pkg::size_mask(dsz));
    end
  end

  // Payload: capture request, operands, result
  always_ff @(posedge clk_i) begin
    if (st_q == rvm_pkg::StIdle && s_axis_tvalid) ins_q <= s_axis_tdata[90:0];
    if (st_q == rvm_pkg::StRead) begin
      s1_q <= ins_q[11] ? imm : rd1;
      s2_q <= ins_q[19] ? imm : rd2;
    end
    res_q <= res_d;
    tk_q  <= tk_d;
    de_q  <= de_d;
    if (st_q == rvm_pkg::StWrite) begin
      out_q <= wr_q ? ((dold & ~rvm_pkg::size_mask(dsz)) |
                       (res_q & rvm_pkg::size_mask(dsz))) : dold;
      tko_q <= tk_q;
      deo_q <= de_q;
    end
  end

  assign m_axis_tdata = {6'd0, deo_q, tko_q, out_q};

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == rvm_pkg::StWrite) |-> !(tk_q && de_q))
    else $error("branch and divide error together");
  a_err_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == rvm_pkg::StWrite && de_q) |-> !wr_q)
    else $error("write after divide error");
  a_div_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> (st_q == rvm_pkg::StExec))
    else $error("divider started outside execute");
endmodule

@@ design/rvm_div.sv @@
// ----------------------------------------------------------------------------
// rvm_div
// Radix-2 restoring divider, one quotient bit a cycle, signed via magnitudes.
// ----------------------------------------------------------------------------
module rvm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rvm_pkg::div_req_t req_i,
  output rvm_pkg::div_rsp_t rsp_o
);
  localparam int unsigned W = rvm_pkg::XLEN;

  logic         busy_q, busy_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [W-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic         negq_q, negq_d, negr_q, negr_d;
  logic         na, nb;
  logic [W:0]   trial;
  logic [W-1:0] shifted;

  assign na = req_i.is_signed & req_i.dividend[W-1];
  assign nb = req_i.is_signed & req_i.divisor[W-1];
  assign shifted = {rem_q[W-2:0], quo_q[W-1]};
  assign trial = {rem_q[W-1], shifted} - {1'b0, dvs_q};

  // Load magnitudes, then shift-subtract one bit a cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    negq_d = negq_q;
    negr_d = negr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 7'(W);
      rem_d  = '0;
      quo_d  = na ? (~req_i.dividend + 1'b1) : req_i.dividend;
      dvs_d  = nb ? (~req_i.divisor + 1'b1) : req_i.divisor;
      negq_d = na ^ nb;
      negr_d = na;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
  end

  // Done pulses the cycle after the last step; fix signs on the way out
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= busy_q && (cnt_q == 7'd1);
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = negq_q ? (~quo_q + 1'b1) : quo_q;
  assign rsp_o.rem  = negr_q ? (~rem_q + 1'b1) : rem_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != 7'd0 && cnt_q <= 7'(W)))
    else $error("divider count out of range");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q)
    else $error("divider did not start");
endmodule
